// ===== rtl/fexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fexp_pkg;

   // Single-precision bit patterns of the constants used by the datapath.
   localparam logic [31:0] LOG2E_BITS    = 32'h3FB8AA3B;
   localparam logic [31:0] LN2_BITS      = 32'h3F317218;
   localparam logic [31:0] CLAMP_HI_BITS = 32'h42B0C0A5;
   localparam logic [31:0] CLAMP_LO_BITS = 32'hC2B0C0A5;
   localparam logic [31:0] ONE_BITS      = 32'h3F800000;
   localparam logic [31:0] ZERO_BITS     = 32'h00000000;
   localparam logic [31:0] INF_BITS      = 32'h7F800000;
   localparam logic [31:0] C0_BITS       = 32'h39506967;
   localparam logic [31:0] C1_BITS       = 32'h3AB743CE;
   localparam logic [31:0] C2_BITS       = 32'h3C088908;
   localparam logic [31:0] C3_BITS       = 32'h3D2AA9C1;
   localparam logic [31:0] C4_BITS       = 32'h3E2AAAAA;
   localparam logic [31:0] C5_BITS       = 32'h3F000000;

   localparam int EXP_BIAS  = 127;
   localparam int MANT_BITS = 23;
   localparam int NUM_OPS   = 19;

   typedef enum logic [2:0] {
      OP_MUL   = 3'd0,
      OP_ADD   = 3'd1,
      OP_SUB   = 3'd2,
      OP_RND   = 3'd3,
      OP_SCALE = 3'd4
   } op_kind_type;

   typedef enum logic [2:0] {
      SRC_X     = 3'd0,
      SRC_R     = 3'd1,
      SRC_R2    = 3'd2,
      SRC_ACC   = 3'd3,
      SRC_CONST = 3'd4
   } src_type;

   typedef enum logic [1:0] {
      DST_ACC = 2'd0,
      DST_R   = 2'd1,
      DST_R2  = 2'd2
   } dst_type;

   typedef struct packed {
      op_kind_type kind;
      src_type     src_a;
      src_type     src_b;
      dst_type     dst;
      logic [31:0] konst;
   } op_desc_type;

   // Working set that travels down the pipeline with each item.
   typedef struct packed {
      logic [31:0]        x;
      logic signed [8:0]  n;
      logic [31:0]        r;
      logic [31:0]        r2;
      logic [31:0]        acc;
   } rec_type;

   // One step per entry; every step is two register stages.
   localparam op_desc_type OP_TABLE [NUM_OPS] = '{
      '{OP_MUL,   SRC_X,   SRC_CONST, DST_ACC, LOG2E_BITS},
      '{OP_RND,   SRC_ACC, SRC_CONST, DST_ACC, ZERO_BITS},
      '{OP_MUL,   SRC_ACC, SRC_CONST, DST_ACC, LN2_BITS},
      '{OP_SUB,   SRC_X,   SRC_ACC,   DST_R,   ZERO_BITS},
      '{OP_MUL,   SRC_R,   SRC_R,     DST_R2,  ZERO_BITS},
      '{OP_MUL,   SRC_R,   SRC_CONST, DST_ACC, C0_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, C1_BITS},
      '{OP_MUL,   SRC_ACC, SRC_R,     DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, C2_BITS},
      '{OP_MUL,   SRC_ACC, SRC_R,     DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, C3_BITS},
      '{OP_MUL,   SRC_ACC, SRC_R,     DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, C4_BITS},
      '{OP_MUL,   SRC_ACC, SRC_R,     DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, C5_BITS},
      '{OP_MUL,   SRC_ACC, SRC_R2,    DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_R,     DST_ACC, ZERO_BITS},
      '{OP_ADD,   SRC_ACC, SRC_CONST, DST_ACC, ONE_BITS},
      '{OP_SCALE, SRC_ACC, SRC_CONST, DST_ACC, ZERO_BITS}
   };

endpackage

`default_nettype wire

// ===== rtl/fexp_op.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fexp_op (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire fexp_pkg::op_desc_type op_desc,
   input  wire logic                 in_valid,
   input  wire fexp_pkg::rec_type    in_rec,
   output logic                      out_valid,
   output fexp_pkg::rec_type         out_rec
);
   import fexp_pkg::*;

   typedef enum logic [1:0] {
      SPEC_NONE = 2'd0,
      SPEC_INF  = 2'd1,
      SPEC_ZERO = 2'd2
   } spec_type;

   // Unrounded result: value = (sig / 2^48) * 2^(exp - bias).
   typedef struct packed {
      logic              sign;
      logic signed [10:0] exp;
      logic [49:0]       sig;
      spec_type          spec;
   } raw_type;

   function automatic logic [31:0] pick(input rec_type rec, input src_type src,
                                        input logic [31:0] konst);
      logic [31:0] v;
      v = konst;
      unique case (src)
         SRC_X:     v = rec.x;
         SRC_R:     v = rec.r;
         SRC_R2:    v = rec.r2;
         SRC_ACC:   v = rec.acc;
         SRC_CONST: v = konst;
         default:   v = konst;
      endcase
      return v;
   endfunction

   function automatic raw_type mul_raw(input logic [31:0] a, input logic [31:0] b);
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] prod;
      raw_type     rw;
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ma = {(a[30:23] != 8'd0), a[22:0]};
      mb = {(b[30:23] != 8'd0), b[22:0]};
      prod = ma * mb;
      rw.sign = a[31] ^ b[31];
      rw.exp = $signed({3'b000, ea}) + $signed({3'b000, eb}) - 11'sd127;
      rw.sig = {prod, 2'b00};
      rw.spec = SPEC_NONE;
      return rw;
   endfunction

   function automatic raw_type add_raw(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] hi;
      logic [31:0] lo;
      logic [7:0]  e_hi;
      logic [7:0]  e_lo;
      logic [7:0]  d;
      logic [49:0] s_hi;
      logic [49:0] s_lo;
      logic [49:0] s_sh;
      logic        lost;
      raw_type     rw;
      if (a[30:0] >= b[30:0]) begin
         hi = a;
         lo = b;
      end else begin
         hi = b;
         lo = a;
      end
      e_hi = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
      e_lo = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
      d = e_hi - e_lo;
      s_hi = {1'b0, (hi[30:23] != 8'd0), hi[22:0], 25'd0};
      s_lo = {1'b0, (lo[30:23] != 8'd0), lo[22:0], 25'd0};
      s_sh = s_lo >> d;
      lost = ((s_sh << d) != s_lo);
      s_sh[0] = s_sh[0] | lost;
      if (hi[31] == lo[31]) begin
         rw.sig = s_hi + s_sh;
      end else begin
         rw.sig = s_hi - s_sh;
      end
      // An exact cancellation gives +0 under round to nearest.
      rw.sign = ((rw.sig == 50'd0) && (hi[31] != lo[31])) ? 1'b0 : hi[31];
      rw.exp = $signed({3'b000, e_hi});
      rw.spec = SPEC_NONE;
      return rw;
   endfunction

   // Magnitude of the nearest integer, ties to even; |a| stays below 256.
   function automatic logic [7:0] rnd_mag(input logic [31:0] a);
      logic [23:0] m;
      logic [4:0]  s;
      logic [23:0] ip;
      logic        half;
      logic        rest;
      logic        up;
      logic [7:0]  mag;
      m = {1'b1, a[22:0]};
      mag = 8'd0;
      s = 5'd0;
      ip = 24'd0;
      half = 1'b0;
      rest = 1'b0;
      up = 1'b0;
      if (a[30:23] >= 8'd126) begin
         s = 5'(8'd150 - a[30:23]);
         ip = m >> s;
         half = m[s - 5'd1];
         rest = |(m & ((24'd1 << (s - 5'd1)) - 24'd1));
         up = half & (rest | ip[0]);
         mag = 8'(ip + {23'd0, up});
      end
      return mag;
   endfunction

   function automatic logic [31:0] norm_round(input raw_type raw);
      logic [5:0]         lead;
      logic signed [11:0] e_full;
      logic signed [11:0] e_norm;
      logic signed [11:0] lsh;
      logic [11:0]        neg_lsh;
      logic [5:0]         rsh;
      logic [49:0]        t;
      logic               sticky;
      logic               inc;
      logic [7:0]         efield;
      logic [30:0]        mag;
      logic [31:0]        res;
      lead = 6'd0;
      for (int i = 0; i < 50; i++) begin
         if (raw.sig[i]) lead = 6'(i);
      end
      e_full = $signed({raw.exp[10], raw.exp});
      e_norm = e_full + $signed({6'd0, lead}) - 12'sd48;
      if (e_norm >= 12'sd1) begin
         lsh = 12'sd48 - $signed({6'd0, lead});
         efield = e_norm[7:0];
      end else begin
         // Below the normal range: hold the exponent at its minimum.
         lsh = e_full - 12'sd1;
         efield = 8'd0;
      end
      neg_lsh = 12'(-lsh);
      rsh = (neg_lsh > 12'd63) ? 6'd63 : neg_lsh[5:0];
      if (!lsh[11]) begin
         t = raw.sig << lsh[5:0];
         sticky = 1'b0;
      end else begin
         t = raw.sig >> rsh;
         sticky = ((t << rsh) != raw.sig);
      end
      sticky = sticky | (|t[23:0]);
      inc = t[24] & (sticky | t[25]);
      mag = {efield, t[47:25]} + {30'd0, inc};
      if (raw.spec == SPEC_INF) begin
         res = INF_BITS;
      end else if (raw.spec == SPEC_ZERO) begin
         res = ZERO_BITS;
      end else if (raw.sig == 50'd0) begin
         res = {raw.sign, 31'd0};
      end else if (e_norm >= 12'sd255) begin
         res = {raw.sign, INF_BITS[30:0]};
      end else begin
         res = {raw.sign, mag};
      end
      return res;
   endfunction

   logic        a_valid_ff;
   rec_type     a_rec_ff;
   rec_type     a_rec_in;
   raw_type     a_raw_ff;
   raw_type     a_raw_in;
   logic        b_valid_ff;
   rec_type     b_rec_ff;
   rec_type     b_rec_in;

   logic [31:0]        opa;
   logic [31:0]        opb;
   logic [7:0]         n_mag;
   logic signed [9:0]  biased;
   logic [31:0]        result;

   // First stage: product, aligned sum or integer conversion, unrounded.
   always_comb begin
      opa = pick(in_rec, op_desc.src_a, op_desc.konst);
      opb = pick(in_rec, op_desc.src_b, op_desc.konst);
      n_mag = rnd_mag(opa);
      biased = $signed({in_rec.n[8], in_rec.n}) + 10'sd127;
      a_rec_in = in_rec;
      a_raw_in = mul_raw(opa, opb);
      unique case (op_desc.kind)
         OP_MUL: a_raw_in = mul_raw(opa, opb);
         OP_ADD: a_raw_in = add_raw(opa, opb);
         OP_SUB: a_raw_in = add_raw(opa, {~opb[31], opb[30:0]});
         OP_RND: begin
            a_rec_in.n = opa[31] ? -$signed({1'b0, n_mag}) : $signed({1'b0, n_mag});
            a_raw_in.sign = opa[31] & (n_mag != 8'd0);
            a_raw_in.exp = 11'sd175;
            a_raw_in.sig = {42'd0, n_mag};
            a_raw_in.spec = SPEC_NONE;
         end
         OP_SCALE: begin
            a_raw_in = mul_raw(opa, {1'b0, biased[7:0], 23'd0});
            if (biased >= 10'sd255) begin
               a_raw_in.spec = SPEC_INF;
            end else if (biased <= 10'sd0) begin
               a_raw_in.spec = SPEC_ZERO;
            end
         end
         default: a_raw_in = mul_raw(opa, opb);
      endcase
   end

   // Second stage: normalize, round to nearest even and write back.
   always_comb begin
      result = norm_round(a_raw_ff);
      b_rec_in = a_rec_ff;
      unique case (op_desc.dst)
         DST_ACC: b_rec_in.acc = result;
         DST_R:   b_rec_in.r = result;
         DST_R2:  b_rec_in.r2 = result;
         default: b_rec_in.acc = result;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_rec_ff <= a_rec_in;
         a_raw_ff <= a_raw_in;
         b_rec_ff <= b_rec_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_rec = b_rec_ff;

endmodule

`default_nettype wire

// ===== rtl/float32_exp_approximation_unit.sv =====
// Pipeline: one register for the input clamp and two registers for each of the 19
// floating-point steps.
// Throughput: one transfer per cycle; the whole pipeline advances together and holds
// only while a finished result waits under rsp_stall.
// Reset: synchronous, active high; it clears the valid bits, data registers keep values.
`timescale 1ns / 1ps
`default_nettype none

module float32_exp_approximation_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_x_bits,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_exp_bits
);
   import fexp_pkg::*;

   // The pipeline moves whenever the output register is empty or its transfer
   // completes in this cycle. A new input transfer is taken in the same cycle
   // that the oldest result leaves.
   logic    enable;

   logic    s0_valid_ff;
   rec_type s0_rec_ff;
   rec_type s0_rec_in;

   logic    stage_valid [NUM_OPS + 1];
   rec_type stage_rec   [NUM_OPS + 1];

   logic [31:0] x_lim;
   logic        x_nan;

   assign enable = ~rsp_valid | ~rsp_stall;
   assign req_stall = ~enable;

   // Clamp to the range where the exponent stays representable. A NaN of either
   // sign is detected apart from the compares and takes the upper bound.
   always_comb begin
      x_nan = (req_x_bits[30:23] == 8'hFF) && (req_x_bits[22:0] != 23'd0);
      x_lim = req_x_bits;
      if (x_nan || !(req_x_bits[31] || (req_x_bits[30:0] < CLAMP_HI_BITS[30:0]))) begin
         x_lim = CLAMP_HI_BITS;
      end else if (req_x_bits[31] && !(req_x_bits[30:0] < CLAMP_HI_BITS[30:0])) begin
         x_lim = CLAMP_LO_BITS;
      end
      s0_rec_in.x = x_lim;
      s0_rec_in.n = 9'sd0;
      s0_rec_in.r = ZERO_BITS;
      s0_rec_in.r2 = ZERO_BITS;
      s0_rec_in.acc = ZERO_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (enable) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s0_rec_ff <= s0_rec_in;
      end
   end

   assign stage_valid[0] = s0_valid_ff;
   assign stage_rec[0] = s0_rec_ff;

   // Range reduction, Horner evaluation of the polynomial, and the final
   // scaling by a power of two, one rounded operation per step.
   for (genvar k = 0; k < NUM_OPS; k++) begin : g_op
      fexp_op u_op (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .op_desc   (OP_TABLE[k]),
         .in_valid  (stage_valid[k]),
         .in_rec    (stage_rec[k]),
         .out_valid (stage_valid[k + 1]),
         .out_rec   (stage_rec[k + 1])
      );
   end

   assign rsp_valid = stage_valid[NUM_OPS];
   assign rsp_exp_bits = stage_rec[NUM_OPS].acc;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the single-precision exp unit.
//
// Every transfer accepted on the request side is pushed through a bit-exact
// integer model of the binary32 datapath (clamp, round-to-even of x*log2(e),
// range reduction, Horner polynomial, exponent scaling). The model rounds every
// product and every sum separately with round-to-nearest-even and keeps
// subnormals. The predicted word goes into a queue, and every transfer on the
// response side is compared with the oldest entry in that queue.
//
// The stimulus starts with a short directed table of extreme and special values.
// Then a long random section follows. Half of the random values are raw 32-bit
// words, so every input bit takes both values. The other half are finite values
// whose exponents land in and around the interesting range.
module tb_top;
   import fexp_pkg::*;

   localparam int RAND_ITEMS  = 700;
   localparam int IDLE_PCT    = 15;
   localparam int QUIET_FIRST = 350;   // no idling on either side from here...
   localparam int QUIET_LAST  = 500;   // ...up to here
   localparam int HOLD_AT     = 150;   // long receiver hold-off starts here
   localparam int HOLD_CYCLES = 200;
   localparam int PAUSE_AT    = 600;   // sender drains the pipe before this item
   localparam int DRAIN_WAIT  = 60;    // comfortably above the pipeline latency
   localparam int CYCLE_LIMIT = 50000;
   localparam logic [31:0] QNAN_BITS = 32'h7FC00000;

   typedef struct {
      logic [31:0] x;
      bit          known;   // the expected word is typed into the table
      logic [31:0] want;
   } stim_row_type;

   // Directed rows. Only results that are obvious by inspection are typed in;
   // the rest are left to the model.
   localparam int DIR_ROWS = 22;
   stim_row_type dir_table [DIR_ROWS] = '{
      '{32'h00000000, 1'b0, 32'h0},   // +0
      '{32'h80000000, 1'b0, 32'h0},   // -0
      '{32'h3F800000, 1'b0, 32'h0},   // 1.0
      '{32'hBF800000, 1'b0, 32'h0},   // -1.0
      '{32'h7F800000, 1'b0, 32'h0},   // +inf takes the upper clamp
      '{32'hFF800000, 1'b1, ZERO_BITS}, // -inf clamps low, the scale flushes to zero
      '{32'h7FC00000, 1'b0, 32'h0},   // quiet NaN takes the upper clamp
      '{32'hFFFFFFFF, 1'b0, 32'h0},   // negative NaN, all ones
      '{32'h7F800001, 1'b0, 32'h0},   // signaling NaN
      '{32'h7F7FFFFF, 1'b0, 32'h0},   // largest finite
      '{32'hFF7FFFFF, 1'b1, ZERO_BITS}, // most negative finite
      '{32'h00000001, 1'b0, 32'h0},   // smallest subnormal
      '{32'h80000001, 1'b0, 32'h0},
      '{CLAMP_HI_BITS, 1'b0, 32'h0},  // exactly on the clamps
      '{CLAMP_LO_BITS, 1'b1, ZERO_BITS},
      '{32'hC2C80000, 1'b1, ZERO_BITS}, // -100.0
      '{LN2_BITS,     1'b0, 32'h0},
      '{32'h42B00000, 1'b0, 32'h0},   // 88.0, near the overflow edge
      '{32'hC2AE0000, 1'b0, 32'h0},   // -87.0, result just above the smallest normal
      '{32'hC2A00000, 1'b0, 32'h0},   // -80.0
      '{32'h41200000, 1'b0, 32'h0},   // 10.0
      '{32'h3EB17218, 1'b0, 32'h0}    // about ln2/2, where the rounding of n flips
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_x_bits = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_exp_bits;

   float32_exp_approximation_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_x_bits   (req_x_bits),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_exp_bits (rsp_exp_bits)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   logic [31:0] stim_x [$];
   bit          stim_known [$];
   logic [31:0] stim_want [$];
   logic [31:0] exp_pending [$];
   int          sent = 0;
   int          received = 0;
   int          errors = 0;
   int          cycles = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          stall_seen = 0;

   // ---------------- binary32 arithmetic in integers ----------------

   function automatic bit fp_is_nan(input logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 0;
   endfunction

   // Splits a finite value into sign, exponent and integer significand so that
   // its magnitude is m * 2^e.
   function automatic void fp_split(input logic [31:0] a, output logic s, output int e,
                                    output logic [63:0] m);
      s = a[31];
      if (a[30:23] == 0) begin
         e = -149;
         m = {41'b0, a[22:0]};
      end else begin
         e = int'(a[30:23]) - 150;
         m = {40'b0, 1'b1, a[22:0]};
      end
   endfunction

   // Rounds the exact value (-1)^s * m * 2^e to binary32, nearest even.
   function automatic logic [31:0] fp_pack(input logic s, input int e, input logic [63:0] m);
      int           p;
      int           lsb;
      int           sh;
      int           be;
      logic [127:0] wide;
      logic [63:0]  q;
      logic [63:0]  rem;
      if (m == 0) return {s, 31'b0};
      p = 63;
      while (!m[p]) p--;
      lsb = p + e - 23;
      if (lsb < -149) lsb = -149;
      sh = lsb - e;
      if (sh <= 0) begin
         q = m << (-sh);
      end else if (sh > 64) begin
         q = 0;   // below half of the smallest subnormal
      end else begin
         wide = {m, 64'b0} >> sh;
         q = wide[127:64];
         rem = wide[63:0];
         if (rem[63] && (rem[62:0] != 0 || q[0])) q = q + 1;
      end
      if (q[24]) begin
         q = q >> 1;
         lsb++;
      end
      if (!q[23]) return {s, 8'd0, q[22:0]};
      be = lsb + 150;
      if (be >= 255) return {s, 8'hFF, 23'b0};
      return {s, be[7:0], q[22:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        sa, sb;
      int          ea, eb;
      logic [63:0] ma, mb;
      bit          a_inf, b_inf, a_zero, b_zero;
      a_inf  = a[30:0] == INF_BITS[30:0];
      b_inf  = b[30:0] == INF_BITS[30:0];
      a_zero = a[30:0] == 0;
      b_zero = b[30:0] == 0;
      if (fp_is_nan(a) || fp_is_nan(b) || (a_inf && b_zero) || (b_inf && a_zero))
         return QNAN_BITS;
      if (a_inf || b_inf) return {a[31] ^ b[31], INF_BITS[30:0]};
      if (a_zero || b_zero) return {a[31] ^ b[31], 31'b0};
      fp_split(a, sa, ea, ma);
      fp_split(b, sb, eb, mb);
      return fp_pack(sa ^ sb, ea + eb, ma * mb);
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
      logic        sa, sb, sr;
      int          ea, eb, d;
      logic [63:0] ma, mb, big, small_part, shifted, sum;
      logic [31:0] t;
      if (fp_is_nan(a) || fp_is_nan(b)) return QNAN_BITS;
      if (a[30:0] == INF_BITS[30:0] && b[30:0] == INF_BITS[30:0])
         return (a[31] == b[31]) ? a : QNAN_BITS;
      if (a[30:0] == INF_BITS[30:0]) return a;
      if (b[30:0] == INF_BITS[30:0]) return b;
      if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'b0};
      if (a[30:0] == 0) return b;
      if (b[30:0] == 0) return a;
      if (b[30:23] > a[30:23]) begin
         t = a;
         a = b;
         b = t;
      end
      fp_split(a, sa, ea, ma);
      fp_split(b, sb, eb, mb);
      d = ea - eb;
      // Work in units of 2^(ea-39); bits of b shifted out collapse into a sticky one.
      big = ma << 39;
      shifted = mb << 39;
      if (d >= 64) begin
         small_part = 64'd1;
      end else begin
         small_part = shifted >> d;
         if ((shifted & ((64'd1 << d) - 1)) != 0) small_part[0] = 1'b1;
      end
      if (sa == sb) begin
         sum = big + small_part;
         sr = sa;
      end else if (big >= small_part) begin
         sum = big - small_part;
         sr = sa;
      end else begin
         sum = small_part - big;
         sr = sb;
      end
      if (sum == 0) return ZERO_BITS;
      return fp_pack(sr, ea - 39, sum);
   endfunction

   // Total order on non-NaN values, with both zeros equal.
   function automatic logic [31:0] fp_key(input logic [31:0] a);
      if (a[30:0] == 0) return 32'h80000000;
      return a[31] ? ~a : (a | 32'h80000000);
   endfunction

   // Nearest integer, ties to even; v is finite and well inside the int range.
   function automatic int fp_round_even(input logic [31:0] v);
      logic        s;
      int          e;
      logic [63:0] m, ip, fr, half_unit;
      fp_split(v, s, e, m);
      if (v[30:0] == 0) return 0;
      if (e >= 0) begin
         ip = m << e;
      end else if (-e >= 40) begin
         ip = 0;
      end else begin
         ip = m >> (-e);
         fr = m & ((64'd1 << (-e)) - 1);
         half_unit = 64'd1 << (-e - 1);
         if (fr > half_unit || (fr == half_unit && ip[0])) ip = ip + 1;
      end
      return s ? -int'(ip) : int'(ip);
   endfunction

   // Expected output word for one input word.
   function automatic logic [31:0] exp_predict(input logic [31:0] x_in);
      logic [31:0] xc, prod, nf, nln2, r, r2, p, y, scale;
      int          n, biased;
      xc = x_in;
      // min then max: the bound wins whenever the comparison fails, NaN included
      if (fp_is_nan(xc) || !(fp_key(xc) < fp_key(CLAMP_HI_BITS))) xc = CLAMP_HI_BITS;
      if (!(fp_key(xc) > fp_key(CLAMP_LO_BITS))) xc = CLAMP_LO_BITS;
      prod = fp_mul(xc, LOG2E_BITS);
      n = fp_round_even(prod);
      nf = fp_pack(n < 0, 0, (n < 0) ? 64'(-n) : 64'(n));
      nln2 = fp_mul(nf, LN2_BITS);
      r = fp_add(xc, {~nln2[31], nln2[30:0]});
      r2 = fp_mul(r, r);
      p = C0_BITS;
      p = fp_add(fp_mul(p, r), C1_BITS);
      p = fp_add(fp_mul(p, r), C2_BITS);
      p = fp_add(fp_mul(p, r), C3_BITS);
      p = fp_add(fp_mul(p, r), C4_BITS);
      p = fp_add(fp_mul(p, r), C5_BITS);
      y = fp_add(fp_add(fp_mul(p, r2), r), ONE_BITS);
      biased = n + EXP_BIAS;
      if (biased >= 255) scale = INF_BITS;
      else if (biased <= 0) scale = ZERO_BITS;
      else scale = {1'b0, biased[7:0], 23'b0};
      return fp_mul(y, scale);
   endfunction

   task automatic report_mismatch(input logic [31:0] x_seen, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH result %0d: exp_bits got %h, expected %h (x %h)",
               received, got, want, x_seen);
      errors++;
   endtask

   // ---------------- stimulus ----------------

   initial begin
      logic [31:0] v;
      foreach (dir_table[i]) begin
         stim_x.push_back(dir_table[i].x);
         stim_known.push_back(dir_table[i].known);
         stim_want.push_back(dir_table[i].want);
      end
      for (int i = 0; i < RAND_ITEMS; i++) begin
         if ($urandom_range(1) == 0) begin
            v = $urandom;
         end else begin
            // finite values from tiny up to past the clamps
            v = {1'($urandom_range(1)), 8'($urandom_range(133, 100)),
                 23'($urandom_range(32'h7FFFFF))};
         end
         stim_x.push_back(v);
         stim_known.push_back(1'b0);
         stim_want.push_back('0);
      end
   end

   function automatic bit in_quiet_window();
      return sent >= QUIET_FIRST && sent < QUIET_LAST;
   endfunction

   // Request side: a transfer is counted when valid and no stall meet at an edge.
   // A new word is only offered when the bus is free, so a stalled word holds.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            exp_pending.push_back(stim_known[sent] ? stim_want[sent]
                                                   : exp_predict(stim_x[sent]));
            sent++;
         end
         if (!req_valid || !req_stall) begin
            if (sent >= stim_x.size()) begin
               req_valid <= 1'b0;
            end else if (sent == PAUSE_AT && exp_pending.size() != 0) begin
               // Let the pipeline run dry before offering the next item.
               req_valid <= 1'b0;
            end else if (!in_quiet_window() && $urandom_range(99) < IDLE_PCT) begin
               req_valid <= 1'b0;
            end else begin
               req_valid  <= 1'b1;
               req_x_bits <= stim_x[sent];
            end
         end
      end
   end

   // Long hold-off on the response side while the sender keeps going, so that
   // the pipeline fills and pushes back on the request side.
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && sent >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
      end else if (in_quiet_window()) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Response side: each transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (req_valid && req_stall) stall_seen++;
         if (rsp_valid && !rsp_stall) begin
            if (exp_pending.size() == 0) begin
               $display("UNEXPECTED result %0d: exp_bits %h with nothing pending",
                        received, rsp_exp_bits);
               errors++;
            end else begin
               want = exp_pending.pop_front();
               if (rsp_exp_bits !== want) report_mismatch(stim_x[received], rsp_exp_bits, want);
            end
            received++;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d sent, %0d received", cycles, sent, received);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (stim_x.size() > 0 && sent == stim_x.size());
      wait (exp_pending.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Covered %0d inputs (%0d directed), %0d results checked, %0d errors.",
               sent, DIR_ROWS, received, errors);
      $display("Request side saw backpressure on %0d cycles.", stall_seen);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/fexp_pkg.sv
rtl/fexp_op.sv
rtl/float32_exp_approximation_unit.sv
tb/tb_top.sv
